FILE: rtl/dsps_pkg.sv
// Shared types and constants for the dense shortest-path search block.
package dsps_pkg;

   localparam int NODE_COUNT_DEF  = 64;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int DIST_BITS_DEF   = 22;

   localparam int NODE_PORT_W   = 6;
   localparam int WEIGHT_PORT_W = 16;
   localparam int DIST_PORT_W   = 22;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic REG_TARGET_NODE = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_DECIDE,
      ST_RELAX,
      ST_WALK,
      ST_WALK_WAIT,
      ST_EMIT,
      ST_FAIL
   } state_type;

   typedef struct packed {
      logic      load;
      state_type phase;
   } cmd_type;

   typedef struct packed {
      logic sweep_end;
      logic found;
      logic hit;
      logic walk_end;
      logic emit_end;
   } sts_type;

endpackage

FILE: rtl/dsps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dsps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dsps_ctrl.sv
// Sequencer for load, search, path walk and path output.
module dsps_ctrl
   import dsps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    req_operation,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      busy      = (state_ff != ST_IDLE);
      cmd.phase = state_ff;
      cmd.load  = start && !busy && (req_operation == OP_LOAD);
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_operation == OP_RUN)) state_in = ST_INIT;
         end
         ST_INIT:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (sts.sweep_end) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (!sts.found) state_in = ST_FAIL;
            else if (sts.hit) state_in = ST_WALK;
            else state_in = ST_RELAX;
         end
         ST_RELAX: begin
            if (sts.sweep_end) state_in = ST_SCAN;
         end
         ST_WALK: begin
            state_in = sts.walk_end ? ST_EMIT : ST_WALK_WAIT;
         end
         ST_WALK_WAIT: state_in = ST_WALK;
         ST_EMIT: begin
            if (sts.emit_end) state_in = ST_IDLE;
         end
         ST_FAIL:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/dsps_datapath.sv
// Weight store, distance and predecessor tables, node sweeps and path output.
module dsps_datapath
   import dsps_pkg::*;
#(
   parameter int NODE_COUNT  = NODE_COUNT_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int DIST_BITS   = DIST_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [NODE_PORT_W-1:0]   req_from_node,
   input  logic [NODE_PORT_W-1:0]   req_to_node,
   input  logic [WEIGHT_PORT_W-1:0] req_edge_weight,
   input  logic                     req_edge_present,
   input  logic [NODE_PORT_W-1:0]   target_node,
   output sts_type                  sts,
   output logic                     rsp_strobe,
   output logic [NODE_PORT_W-1:0]   rsp_path_node,
   output logic [DIST_PORT_W-1:0]   rsp_total_distance,
   output logic                     rsp_reachable,
   output logic                     rsp_last_node
);

   localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int CW = NW + 1;
   localparam int AW = $clog2(NODE_COUNT * NODE_COUNT);
   localparam int EW = WEIGHT_BITS + 1;
   localparam int SW = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
   localparam logic [CW-1:0] NODE_END = CW'(NODE_COUNT);
   localparam logic [SW-1:0] DIST_TOP = SW'({DIST_BITS{1'b1}});

   // sweep counter and read pipeline register
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 rd_v_ff, rd_v_in;
   logic [NW-1:0]        rd_idx_ff, rd_idx_in;
   // scan result
   logic                 found_ff, found_in;
   logic [DIST_BITS-1:0] best_ff, best_in;
   logic [NW-1:0]        u_ff, u_in;
   logic [DIST_BITS-1:0] total_ff, total_in;
   // per-node flags
   logic [NODE_COUNT-1:0] valid_ff, valid_in;
   logic [NODE_COUNT-1:0] queue_ff, queue_in;
   logic [NODE_COUNT-1:0] visited_ff, visited_in;
   // path walk
   logic [NW-1:0]        node_ff, node_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   // result register
   logic                   strobe_ff, strobe_in;
   logic [NODE_PORT_W-1:0] pnode_ff, pnode_in;
   logic [DIST_PORT_W-1:0] ptotal_ff, ptotal_in;
   logic                   reach_ff, reach_in;
   logic                   last_ff, last_in;

   // memory ports
   logic                 w_we;
   logic [AW-1:0]        w_waddr, w_raddr;
   logic [EW-1:0]        w_wdata, w_rdata;
   logic                 d_we;
   logic [NW-1:0]        d_waddr, d_raddr;
   logic [DIST_BITS-1:0] d_wdata, d_rdata;
   logic                 p_we;
   logic [NW-1:0]        p_rdata;
   logic                 b_we;
   logic [NW-1:0]        b_rdata, b_raddr;

   logic                 in_range, issue, upd;
   logic [SW-1:0]        alt_full;
   logic [DIST_BITS-1:0] alt;
   logic [CW-1:0]        idx_dec;

   dsps_ram #(.WIDTH(EW), .DEPTH(NODE_COUNT * NODE_COUNT)) u_weight (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(w_wdata),
      .rd_addr(w_raddr), .rd_data(w_rdata));

   dsps_ram #(.WIDTH(DIST_BITS), .DEPTH(NODE_COUNT)) u_dist (
      .clock(clock), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
      .rd_addr(d_raddr), .rd_data(d_rdata));

   dsps_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_pred (
      .clock(clock), .wr_en(p_we), .wr_addr(rd_idx_ff), .wr_data(u_ff),
      .rd_addr(node_ff), .rd_data(p_rdata));

   dsps_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_path (
      .clock(clock), .wr_en(b_we), .wr_addr(cnt_ff[NW-1:0]), .wr_data(node_ff),
      .rd_addr(b_raddr), .rd_data(b_rdata));

   assign in_range = (32'(req_from_node) < 32'(NODE_COUNT)) &&
                     (32'(req_to_node) < 32'(NODE_COUNT));
   assign w_we     = cmd.load && in_range;
   assign w_waddr  = AW'(NW'(req_from_node)) * AW'(NODE_COUNT) + AW'(NW'(req_to_node));
   assign w_wdata  = {req_edge_present, WEIGHT_BITS'(req_edge_weight)};
   assign w_raddr  = AW'(u_ff) * AW'(NODE_COUNT) + AW'(idx_ff[NW-1:0]);
   assign d_raddr  = idx_ff[NW-1:0];
   assign idx_dec  = idx_ff - CW'(1);
   assign b_raddr  = idx_dec[NW-1:0];

   assign alt_full = SW'(best_ff) + SW'(w_rdata[WEIGHT_BITS-1:0]);
   assign alt      = (alt_full > DIST_TOP) ? DIST_BITS'(DIST_TOP) : DIST_BITS'(alt_full);
   assign upd      = rd_v_ff && w_rdata[WEIGHT_BITS] &&
                     (!valid_ff[rd_idx_ff] || (alt < d_rdata));

   assign sts.sweep_end = (idx_ff == NODE_END);
   assign sts.emit_end  = (idx_ff == '0);
   assign sts.found     = found_ff;
   assign sts.hit       = found_ff && (32'(u_ff) == 32'(target_node));
   assign sts.walk_end  = (node_ff == '0) || (cnt_ff == NODE_END - CW'(1));

   always_comb begin
      idx_in     = idx_ff;
      rd_v_in    = 1'b0;
      rd_idx_in  = idx_ff[NW-1:0];
      found_in   = found_ff;
      best_in    = best_ff;
      u_in       = u_ff;
      total_in   = total_ff;
      valid_in   = valid_ff;
      queue_in   = queue_ff;
      visited_in = visited_ff;
      node_in    = node_ff;
      cnt_in     = cnt_ff;
      strobe_in  = 1'b0;
      pnode_in   = pnode_ff;
      ptotal_in  = ptotal_ff;
      reach_in   = reach_ff;
      last_in    = last_ff;
      d_we       = 1'b0;
      d_waddr    = rd_idx_ff;
      d_wdata    = alt;
      p_we       = 1'b0;
      b_we       = 1'b0;
      issue      = (idx_ff != NODE_END);
      unique case (cmd.phase)
         ST_INIT: begin
            valid_in    = '0;
            valid_in[0] = 1'b1;
            queue_in    = '0;
            queue_in[0] = 1'b1;
            visited_in  = '0;
            d_we        = 1'b1;
            d_waddr     = '0;
            d_wdata     = '0;
            idx_in      = '0;
            found_in    = 1'b0;
         end
         ST_SCAN: begin
            if (issue) idx_in = idx_ff + CW'(1);
            rd_v_in = issue;
            // lowest index wins ties: strict compare in ascending order
            if (rd_v_ff && queue_ff[rd_idx_ff] && (!found_ff || (d_rdata < best_ff))) begin
               found_in = 1'b1;
               best_in  = d_rdata;
               u_in     = rd_idx_ff;
            end
         end
         ST_DECIDE: begin
            queue_in[u_ff]   = 1'b0;
            visited_in[u_ff] = 1'b1;
            idx_in           = '0;
            node_in          = NW'(target_node);
            cnt_in           = '0;
            total_in         = best_ff;
         end
         ST_RELAX: begin
            if (issue) idx_in = idx_ff + CW'(1);
            rd_v_in = issue;
            if (upd) begin
               d_we                 = 1'b1;
               p_we                 = 1'b1;
               valid_in[rd_idx_ff]  = 1'b1;
               if (!visited_ff[rd_idx_ff]) queue_in[rd_idx_ff] = 1'b1;
            end
            if (!issue) begin
               idx_in   = '0;
               found_in = 1'b0;
            end
         end
         ST_WALK: begin
            b_we   = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (sts.walk_end) idx_in = cnt_ff + CW'(1);
         end
         ST_WALK_WAIT: begin
            node_in = p_rdata;
         end
         ST_EMIT: begin
            if (idx_ff != '0) begin
               idx_in    = idx_dec;
               rd_v_in   = 1'b1;
               rd_idx_in = idx_dec[NW-1:0];
            end
            if (rd_v_ff) begin
               strobe_in = 1'b1;
               pnode_in  = NODE_PORT_W'(b_rdata);
               ptotal_in = DIST_PORT_W'(total_ff);
               reach_in  = 1'b1;
               last_in   = (rd_idx_ff == '0);
            end
         end
         ST_FAIL: begin
            strobe_in = 1'b1;
            pnode_in  = '0;
            ptotal_in = '0;
            reach_in  = 1'b0;
            last_in   = 1'b1;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         rd_v_ff   <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
         rd_v_ff   <= rd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rd_idx_ff  <= rd_idx_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      u_ff       <= u_in;
      total_ff   <= total_in;
      valid_ff   <= valid_in;
      queue_ff   <= queue_in;
      visited_ff <= visited_in;
      node_ff    <= node_in;
      cnt_ff     <= cnt_in;
      pnode_ff   <= pnode_in;
      ptotal_ff  <= ptotal_in;
      reach_ff   <= reach_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_path_node      = pnode_ff;
   assign rsp_total_distance = ptotal_ff;
   assign rsp_reachable      = reach_ff;
   assign rsp_last_node      = last_ff;

endmodule

FILE: rtl/dense_shortest_path_search_top.sv
// Dense shortest-path search: a load writes one edge and busy stays low.
// A run does a setup step, then per node taken scans for the least queued node
// and relaxes its row (none for the target), each through the single read port
// of the distance and weight memories; with no queued node left it gives a
// single unreachable result, else it walks predecessors and outputs the path nodes.
// Results come one per cycle, registered; synchronous reset returns to idle.
module dense_shortest_path_search_top
   import dsps_pkg::*;
#(
   parameter int NODE_COUNT  = NODE_COUNT_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int DIST_BITS   = DIST_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_operation,
   input  logic [NODE_PORT_W-1:0]   req_from_node,
   input  logic [NODE_PORT_W-1:0]   req_to_node,
   input  logic [WEIGHT_PORT_W-1:0] req_edge_weight,
   input  logic                     req_edge_present,
   output logic                     rsp_strobe,
   output logic [NODE_PORT_W-1:0]   rsp_path_node,
   output logic [DIST_PORT_W-1:0]   rsp_total_distance,
   output logic                     rsp_reachable,
   output logic                     rsp_last_node,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready
);

   cmd_type                cmd;
   sts_type                sts;
   logic [NODE_PORT_W-1:0] target_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '1;
      end else if (psel && penable && pwrite && (paddr[2] == REG_TARGET_NODE)) begin
         target_ff <= pwdata[NODE_PORT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_TARGET_NODE) ? CSR_DATA_W'(target_ff) : '0;

   dsps_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_operation(req_operation),
      .sts(sts), .cmd(cmd), .busy(busy));

   dsps_datapath #(
      .NODE_COUNT(NODE_COUNT), .WEIGHT_BITS(WEIGHT_BITS), .DIST_BITS(DIST_BITS)
   ) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_from_node(req_from_node), .req_to_node(req_to_node),
      .req_edge_weight(req_edge_weight), .req_edge_present(req_edge_present),
      .target_node(target_ff), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp_path_node(rsp_path_node),
      .rsp_total_distance(rsp_total_distance), .rsp_reachable(rsp_reachable),
      .rsp_last_node(rsp_last_node));

endmodule

FILE: rtl/dsps_checker.sv
// Port-level checks on the search block, bound to the top level.
module dsps_checker
   import dsps_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   req_operation,
   input logic                   rsp_strobe,
   input logic [NODE_PORT_W-1:0] rsp_path_node,
   input logic [DIST_PORT_W-1:0] rsp_total_distance,
   input logic                   rsp_reachable,
   input logic                   rsp_last_node
);

   a_unreach_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_reachable |-> rsp_last_node && (rsp_path_node == '0) &&
      (rsp_total_distance == '0))
      else $error("unreachable result is not a single zero transfer");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == OP_RUN) |=> busy)
      else $error("run accepted without going busy");

   a_path_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_node |=> rsp_strobe)
      else $error("path transfer burst broken before last node");

   a_path_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_node |-> busy)
      else $error("path still streaming while idle");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !busy && !rsp_strobe && !$past(busy) |=> !rsp_strobe)
      else $error("transfer without a run");

endmodule

bind dense_shortest_path_search_top dsps_checker u_dsps_checker (.*);
